// ===== hw/rtl/cbx_pkg.sv =====
// Package for the CB-prefix bit/shift executor.
// Opcode field codes, cycle counts and the structs passed between modules.
// No dependencies.
`default_nettype none

package cbx_pkg;

    localparam int NUM_REGS = 7;

    typedef logic [2:0] reg_slot_t;

    localparam logic [2:0] SEL_MEM = 3'd6;
    localparam logic [2:0] SEL_A   = 3'd7;
    localparam reg_slot_t  SLOT_A  = 3'd6;
    localparam reg_slot_t  SLOT_H  = 3'd4;
    localparam reg_slot_t  SLOT_L  = 3'd5;

    localparam logic [1:0] GRP_SHIFT = 2'd0;
    localparam logic [1:0] GRP_BIT   = 2'd1;
    localparam logic [1:0] GRP_RES   = 2'd2;
    localparam logic [1:0] GRP_SET   = 2'd3;

    localparam logic [2:0] FN_RLC  = 3'd0;
    localparam logic [2:0] FN_RRC  = 3'd1;
    localparam logic [2:0] FN_RL   = 3'd2;
    localparam logic [2:0] FN_RR   = 3'd3;
    localparam logic [2:0] FN_SLA  = 3'd4;
    localparam logic [2:0] FN_SRA  = 3'd5;
    localparam logic [2:0] FN_SWAP = 3'd6;
    localparam logic [2:0] FN_SRL  = 3'd7;

    localparam logic [4:0] CYC_REG     = 5'd8;
    localparam logic [4:0] CYC_BIT_MEM = 5'd12;
    localparam logic [4:0] CYC_MEM     = 5'd16;

    // Z, N, H, C
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [7:0]  value;
        logic        reg_write;
        logic        mem_write;
        logic [7:0]  mem_write_data;
        flags_t      flags;
        logic [4:0]  cycles;
    } exec_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cbx_regfile.sv =====
// Register file B,C,D,E,H,L,A plus flag register.
// Depends on cbx_pkg.
`default_nettype none

module cbx_regfile
    import cbx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [2:0]  sel,
    output logic [7:0]       rd_value,
    output flags_t           rd_flags,
    output logic [15:0]      hl,
    input  wire logic        wr_en,
    input  wire logic        wr_reg,
    input  wire logic [7:0]  wr_value,
    input  wire flags_t      wr_flags
);

    logic [7:0] regs_reg [NUM_REGS];
    flags_t     flags_reg;
    reg_slot_t  slot;

    assign slot     = (sel == SEL_A) ? SLOT_A : sel;
    assign rd_value = regs_reg[slot];
    assign rd_flags = flags_reg;
    assign hl       = {regs_reg[SLOT_H], regs_reg[SLOT_L]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'h00;
            end
            flags_reg <= '0;
        end
        else if (wr_en)
        begin
            flags_reg <= wr_flags;
            if (wr_reg)
            begin
                regs_reg[slot] <= wr_value;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cbx_alu.sv =====
// Combinational execute of one CB opcode: shift/rotate, BIT, RES, SET.
// Depends on cbx_pkg.
`default_nettype none

module cbx_alu
    import cbx_pkg::*;
(
    input  wire logic [7:0]  opcode,
    input  wire logic [7:0]  mem_read_data,
    input  wire logic [7:0]  reg_value,
    input  wire flags_t      flags_in,
    output exec_result_t     res
);

    logic [2:0] sel;
    logic [2:0] fn;
    logic [1:0] grp;
    logic       is_mem;
    logic [7:0] v;
    logic [7:0] r;
    logic [7:0] mask;
    logic       cout;
    logic       writes;
    flags_t     f;

    assign sel    = opcode[2:0];
    assign fn     = opcode[5:3];
    assign grp    = opcode[7:6];
    assign is_mem = (sel == SEL_MEM);
    assign v      = is_mem ? mem_read_data : reg_value;
    assign mask   = 8'h01 << fn;

    always_comb
    begin
        r      = v;
        cout   = 1'b0;
        writes = 1'b1;
        f      = flags_in;
        case (grp)
            GRP_SHIFT:
            begin
                case (fn)
                    FN_RLC:  begin cout = v[7]; r = {v[6:0], v[7]}; end
                    FN_RRC:  begin cout = v[0]; r = {v[0], v[7:1]}; end
                    FN_RL:   begin cout = v[7]; r = {v[6:0], flags_in.c}; end
                    FN_RR:   begin cout = v[0]; r = {flags_in.c, v[7:1]}; end
                    FN_SLA:  begin cout = v[7]; r = {v[6:0], 1'b0}; end
                    FN_SRA:  begin cout = v[0]; r = {v[7], v[7:1]}; end
                    FN_SWAP: begin cout = 1'b0; r = {v[3:0], v[7:4]}; end
                    default: begin cout = v[0]; r = {1'b0, v[7:1]}; end
                endcase
                f.z = (r == 8'h00);
                f.n = 1'b0;
                f.h = 1'b0;
                f.c = cout;
            end
            GRP_BIT:
            begin
                writes = 1'b0;
                f.z    = ((v & mask) == 8'h00);
                f.n    = 1'b0;
                f.h    = 1'b1;
            end
            GRP_RES: r = v & ~mask;
            default: r = v | mask;
        endcase
    end

    always_comb
    begin
        res.value          = r;
        res.reg_write      = !is_mem && writes;
        res.mem_write      = is_mem && writes;
        res.mem_write_data = (is_mem && writes) ? r : 8'h00;
        res.flags          = f;
        if (!is_mem)
        begin
            res.cycles = CYC_REG;
        end
        else
        begin
            res.cycles = writes ? CYC_MEM : CYC_BIT_MEM;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cb_prefix_bit_shift_execute.sv =====
// Top level of the CB-prefix bit/shift executor: input register, execute, result register.
// Depends on cbx_pkg, cbx_regfile, cbx_alu.
//
// Takes one CB-prefixed opcode per request and returns one result per request, in order.
// A request is registered on entry, executed against the register file and flags once the
// result register is free, and lands in the result register; the register file updates at
// that same edge, so a following request sees it with no bubble. Sustained rate is one
// request per cycle while the result is taken. Input ready drops only while both the input
// register and the result register are full and the result is not taken.
`default_nettype none

module cb_prefix_bit_shift_execute
    import cbx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] opcode, [15:8] mem_read_data
    input  wire logic [15:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] result_value, [8] mem_write, [24:9] mem_address, [32:25] mem_write_data,
    // [33] zero_flag, [34] subtract_flag, [35] half_carry_flag, [36] carry_flag,
    // [41:37] cycles, [47:42] zero
    output logic [47:0]      m_axis_tdata
);

    logic         in_valid_reg;
    logic [7:0]   opcode_reg;
    logic [7:0]   mem_data_reg;
    logic         out_valid_reg;
    logic [47:0]  out_data_reg;

    logic         out_free;
    logic         exec_fire;
    logic         in_fire;
    logic [7:0]   reg_value;
    flags_t       cur_flags;
    logic [15:0]  hl;
    exec_result_t res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign exec_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    cbx_regfile u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .sel      (opcode_reg[2:0]),
        .rd_value (reg_value),
        .rd_flags (cur_flags),
        .hl       (hl),
        .wr_en    (exec_fire),
        .wr_reg   (res.reg_write),
        .wr_value (res.value),
        .wr_flags (res.flags)
    );

    cbx_alu u_alu (
        .opcode        (opcode_reg),
        .mem_read_data (mem_data_reg),
        .reg_value     (reg_value),
        .flags_in      (cur_flags),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg   <= s_axis_tdata[7:0];
            mem_data_reg <= s_axis_tdata[15:8];
        end
        if (exec_fire)
        begin
            out_data_reg <= {6'b0, res.cycles, res.flags.c, res.flags.h, res.flags.n,
                             res.flags.z, res.mem_write_data, hl, res.mem_write, res.value};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
